@@ rtl/kst_pkg.sv @@
// Keyed statistics table: shared types, codes and constants.
// No dependencies; used by every file of the block.
`default_nettype none
package kst_pkg;

    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int SLOT_W   = 10;
    localparam int CALLS_W  = 48;

    localparam logic [1:0] FUNC_RECORD = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [2:0] ST_UPDATED   = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_IGNORED   = 3'd3;
    localparam logic [2:0] ST_READ_OK   = 3'd4;
    localparam logic [2:0] ST_READ_NONE = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    typedef enum logic [1:0] {
        OP_RECORD,
        OP_READ,
        OP_CLEAR,
        OP_IGNORE
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] user_id;
        logic [31:0] db_id;
        logic [63:0] query_id;
        logic [31:0] elapsed_us;
        logic [31:0] row_count;
        logic [9:0]  slot_index;
    } cmd_t;

    typedef struct packed {
        logic [31:0]        user_id;
        logic [31:0]        db_id;
        logic [63:0]        query_id;
        logic [CALLS_W-1:0] calls;
        logic [63:0]        total_us;
        logic [31:0]        min_us;
        logic [31:0]        max_us;
        logic [63:0]        rows_total;
    } entry_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [SLOT_W-1:0] slot;
        entry_t            entry;
    } result_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RD,
        B_CMP
    } bstate_t;

endpackage
`default_nettype wire

@@ rtl/kst_front.sv @@
// Keyed statistics table front end: accepts transactions, classifies them
// and holds them in a two-entry queue for the back end. Uses kst_pkg.
`default_nettype none
module kst_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [1:0]    s_func,
    input  wire logic [31:0]   s_user_id,
    input  wire logic [31:0]   s_db_id,
    input  wire logic [63:0]   s_query_id,
    input  wire logic [31:0]   s_elapsed_us,
    input  wire logic [31:0]   s_row_count,
    input  wire logic [9:0]    s_slot_index,
    output logic               q_valid,
    output kst_pkg::cmd_t      q_cmd,
    input  wire logic          q_pop
);

    kst_pkg::cmd_t fifo_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    kst_pkg::cmd_t cmd_in;
    logic          push;

    always_comb begin
        cmd_in.user_id    = s_user_id;
        cmd_in.db_id      = s_db_id;
        cmd_in.query_id   = s_query_id;
        cmd_in.elapsed_us = s_elapsed_us;
        cmd_in.row_count  = s_row_count;
        cmd_in.slot_index = s_slot_index;
        case (s_func)
            kst_pkg::FUNC_RECORD: begin
                // zero query id is untracked
                cmd_in.op = (s_query_id == 64'd0) ? kst_pkg::OP_IGNORE : kst_pkg::OP_RECORD;
            end
            kst_pkg::FUNC_READ:  cmd_in.op = kst_pkg::OP_READ;
            kst_pkg::FUNC_CLEAR: cmd_in.op = kst_pkg::OP_CLEAR;
            default:             cmd_in.op = kst_pkg::OP_IGNORE;
        endcase
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_cmd   = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule
`default_nettype wire

@@ rtl/kst_back.sv @@
// Keyed statistics table back end: entry memory, fill count, key search
// sequencer and result register. Uses kst_pkg.
`default_nettype none
module kst_back #(
    parameter int TABLE_ENTRIES = kst_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    input  wire kst_pkg::cmd_t q_cmd,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output kst_pkg::result_t   m_result
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > kst_pkg::SLOT_W) ? CNT_W : kst_pkg::SLOT_W;

    kst_pkg::entry_t mem [TABLE_ENTRIES];
    kst_pkg::entry_t rdata_reg;

    kst_pkg::bstate_t state_reg, state_next;
    kst_pkg::cmd_t    cmd_reg, cmd_next;
    logic [IDX_W-1:0] probe_reg, probe_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             m_valid_reg, m_valid_next;
    kst_pkg::result_t out_reg, out_next;

    logic             we;
    logic [IDX_W-1:0] waddr;
    kst_pkg::entry_t  wdata;
    kst_pkg::entry_t  upd, ins;
    logic             key_hit, last_probe, table_full, read_ok;
    logic [64:0]      tot_sum, row_sum;

    assign q_pop    = (state_reg == kst_pkg::B_IDLE) && q_valid && !m_valid_reg;
    assign m_valid  = m_valid_reg;
    assign m_result = out_reg;

    assign table_full = (fill_reg == CNT_W'(TABLE_ENTRIES));
    assign read_ok    = CMP_W'(q_cmd.slot_index) < CMP_W'(fill_reg);
    assign last_probe = (CNT_W'(probe_reg) + CNT_W'(1)) == fill_reg;
    assign key_hit    = (rdata_reg.user_id == cmd_reg.user_id) &&
                        (rdata_reg.db_id == cmd_reg.db_id) &&
                        (rdata_reg.query_id == cmd_reg.query_id);

    // Update of a matching entry, sums saturate
    always_comb begin
        tot_sum = {1'b0, rdata_reg.total_us} + {33'd0, cmd_reg.elapsed_us};
        row_sum = {1'b0, rdata_reg.rows_total} + {33'd0, cmd_reg.row_count};
        upd = rdata_reg;
        upd.calls      = (&rdata_reg.calls) ? rdata_reg.calls
                                            : rdata_reg.calls + kst_pkg::CALLS_W'(1);
        upd.total_us   = tot_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : tot_sum[63:0];
        upd.rows_total = row_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : row_sum[63:0];
        upd.min_us     = (cmd_reg.elapsed_us < rdata_reg.min_us) ? cmd_reg.elapsed_us
                                                                 : rdata_reg.min_us;
        upd.max_us     = (cmd_reg.elapsed_us > rdata_reg.max_us) ? cmd_reg.elapsed_us
                                                                 : rdata_reg.max_us;
    end

    // New entry built from the transaction in flight (queue head in idle)
    always_comb begin
        kst_pkg::cmd_t c;
        c = (state_reg == kst_pkg::B_IDLE) ? q_cmd : cmd_reg;
        ins.user_id    = c.user_id;
        ins.db_id      = c.db_id;
        ins.query_id   = c.query_id;
        ins.calls      = kst_pkg::CALLS_W'(1);
        ins.total_us   = {32'd0, c.elapsed_us};
        ins.min_us     = c.elapsed_us;
        ins.max_us     = c.elapsed_us;
        ins.rows_total = {32'd0, c.row_count};
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        probe_next   = probe_reg;
        fill_next    = fill_reg;
        m_valid_next = m_valid_reg && !m_ready;
        out_next     = out_reg;
        we           = 1'b0;
        waddr        = IDX_W'(fill_reg);
        wdata        = ins;
        case (state_reg)
            kst_pkg::B_IDLE: begin
                if (q_pop) begin
                    cmd_next = q_cmd;
                    out_next = '0;
                    case (q_cmd.op)
                        kst_pkg::OP_RECORD: begin
                            if (fill_reg == '0) begin
                                we           = 1'b1;
                                fill_next    = fill_reg + CNT_W'(1);
                                out_next.status = kst_pkg::ST_INSERTED;
                                out_next.entry  = ins;
                                m_valid_next = 1'b1;
                            end else begin
                                probe_next = '0;
                                state_next = kst_pkg::B_RD;
                            end
                        end
                        kst_pkg::OP_READ: begin
                            if (read_ok) begin
                                probe_next = IDX_W'(q_cmd.slot_index);
                                state_next = kst_pkg::B_RD;
                            end else begin
                                out_next.status = kst_pkg::ST_READ_NONE;
                                out_next.slot   = q_cmd.slot_index;
                                m_valid_next    = 1'b1;
                            end
                        end
                        kst_pkg::OP_CLEAR: begin
                            fill_next       = '0;
                            out_next.status = kst_pkg::ST_CLEARED;
                            m_valid_next    = 1'b1;
                        end
                        default: begin
                            out_next.status = kst_pkg::ST_IGNORED;
                            m_valid_next    = 1'b1;
                        end
                    endcase
                end
            end
            kst_pkg::B_RD: begin
                state_next = kst_pkg::B_CMP;
            end
            kst_pkg::B_CMP: begin
                state_next = kst_pkg::B_IDLE;
                out_next   = '0;
                if (cmd_reg.op == kst_pkg::OP_READ) begin
                    out_next.status = kst_pkg::ST_READ_OK;
                    out_next.slot   = kst_pkg::SLOT_W'(probe_reg);
                    out_next.entry  = rdata_reg;
                    m_valid_next    = 1'b1;
                end else if (key_hit) begin
                    we              = 1'b1;
                    waddr           = probe_reg;
                    wdata           = upd;
                    out_next.status = kst_pkg::ST_UPDATED;
                    out_next.slot   = kst_pkg::SLOT_W'(probe_reg);
                    out_next.entry  = upd;
                    m_valid_next    = 1'b1;
                end else if (!last_probe) begin
                    probe_next = probe_reg + IDX_W'(1);
                    state_next = kst_pkg::B_RD;
                end else if (table_full) begin
                    out_next.status = kst_pkg::ST_FULL;
                    m_valid_next    = 1'b1;
                end else begin
                    we              = 1'b1;
                    fill_next       = fill_reg + CNT_W'(1);
                    out_next.status = kst_pkg::ST_INSERTED;
                    out_next.slot   = kst_pkg::SLOT_W'(fill_reg);
                    out_next.entry  = ins;
                    m_valid_next    = 1'b1;
                end
            end
            default: state_next = kst_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kst_pkg::B_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        probe_reg <= probe_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[probe_reg];
    end

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count past table size");

    a_pop_free: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !m_valid_reg && state_reg == kst_pkg::B_IDLE)
        else $error("transaction taken while result pending");

    a_probe_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == kst_pkg::B_CMP |-> CNT_W'(probe_reg) < fill_reg)
        else $error("probe beyond filled slots");

    a_busy_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == kst_pkg::B_RD |-> !m_valid_reg)
        else $error("result pending during search");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && q_cmd.op == kst_pkg::OP_CLEAR |=> fill_reg == '0)
        else $error("clear did not empty table");

endmodule
`default_nettype wire

@@ rtl/keyed_statistics_table.sv @@
// Keyed statistics table top level: front end queue plus back end search.
// Depends on kst_pkg, kst_front and kst_back.
`default_nettype none
// Per-key statistics over (user, database, query id). Occupied slots always
// form a prefix 0..fill-1, so a record scans that prefix from slot 0, each
// slot read (B_RD) and then compared (B_CMP) through the registered read of
// the entry memory; a new key lands in slot fill in the same pass. A read
// fetches its slot the same way; clear and ignored records answer straight
// from idle, as clear only resets the fill count. No clearing pass after
// reset. A two-entry queue lets input transactions land while the back
// end searches; one result register holds the answer until taken.
module keyed_statistics_table #(
    parameter int TABLE_ENTRIES = kst_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [1:0]   s_func,
    input  wire logic [31:0]  s_user_id,
    input  wire logic [31:0]  s_db_id,
    input  wire logic [63:0]  s_query_id,
    input  wire logic [31:0]  s_elapsed_us,
    input  wire logic [31:0]  s_row_count,
    input  wire logic [9:0]   s_slot_index,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [2:0]        m_status,
    output logic [9:0]        m_slot,
    output logic [31:0]       m_entry_user,
    output logic [31:0]       m_entry_db,
    output logic [63:0]       m_entry_query,
    output logic [47:0]       m_calls,
    output logic [63:0]       m_total_us,
    output logic [31:0]       m_min_us,
    output logic [31:0]       m_max_us,
    output logic [63:0]       m_rows_total
);

    logic             q_valid;
    logic             q_pop;
    kst_pkg::cmd_t    q_cmd;
    kst_pkg::result_t result;

    kst_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_user_id    (s_user_id),
        .s_db_id      (s_db_id),
        .s_query_id   (s_query_id),
        .s_elapsed_us (s_elapsed_us),
        .s_row_count  (s_row_count),
        .s_slot_index (s_slot_index),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop)
    );

    kst_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_status      = result.status;
    assign m_slot        = result.slot;
    assign m_entry_user  = result.entry.user_id;
    assign m_entry_db    = result.entry.db_id;
    assign m_entry_query = result.entry.query_id;
    assign m_calls       = result.entry.calls;
    assign m_total_us    = result.entry.total_us;
    assign m_min_us      = result.entry.min_us;
    assign m_max_us      = result.entry.max_us;
    assign m_rows_total  = result.entry.rows_total;

endmodule
`default_nettype wire
